>>> hdl/sis_pkg.sv
package sis_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned AW       = 8;
  localparam int unsigned CW       = 9;

  typedef enum logic [1:0] {
    CMD_FIND   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_GET    = 2'd3
  } sis_cmd_e;

  typedef struct packed {
    sis_cmd_e           command;
    logic signed [63:0] operand_value;
    logic [AW-1:0]      entry_index;
  } sis_req_t;

  typedef struct packed {
    logic               ok;
    logic [CW-1:0]      position;
    logic signed [15:0] entry_value;
    logic [CW-1:0]      count_now;
    logic               store_full;
    logic               upgrade_advised;
  } sis_rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic probe;
    logic cmp;
    logic get_rd;
    logic get_cap;
    logic su_init;
    logic su_step;
    logic dn_init;
    logic dn_step;
    logic wr_new;
    logic set_full;
    logic set_ok;
    logic cnt_dec;
    logic finish;
  } sis_ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    sis_cmd_e cmd;
    logic     idx_ok;
    logic     oor;
    logic     search_go;
    logic     hit;
    logic     full;
    logic     su_last;
    logic     dn_last;
  } sis_sts_t;

endpackage

>>> hdl/sorted_int16_set_top.sv
// Sorted set of distinct signed 16-bit values, 256 entries.
//
// Command channel: drive req_i and raise start; the transaction is taken at
// a rising edge with start high and busy low. busy stays high until the
// result has been formed. Commands: find, add, remove, get by index.
// Result channel: rsp_o is valid for exactly one cycle while done_o is high.
// The receiver cannot stall; it must take the result in that cycle. A new
// command may be issued in the same cycle that done_o is high.
// Config channel: cfg_valid_i/cfg_ready_o write upgrade_count (cfg_data_i);
// ready is always high. Write it only while the block is idle.
//
// A get reads the store once at the requested index. Find, add and remove
// run a binary search with one read and one compare per search step
// through the single store read port. Add and remove then move each
// entry above the position by one slot, one entry per cycle. The worst
// case is an add at position 0 into a store holding 255 entries.
//
// Reset clears the entry count and sets upgrade_count to 256; the store
// itself is not cleared and only entries below the count are ever used.
module sorted_int16_set_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sis_pkg::sis_req_t req_i,
  output logic              done_o,
  output sis_pkg::sis_rsp_t rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [8:0]        cfg_data_i
);
  import sis_pkg::*;

  sis_ctl_t ctl;
  sis_sts_t sts;

  // Config writes must only be issued while idle; the block does not enforce this and always takes them.
  assign cfg_ready_o = 1'b1;

  sis_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  sis_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .rsp_o       (rsp_o),
    .rsp_valid_o (done_o)
  );

endmodule

>>> hdl/sis_ram.sv
module sis_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/sis_ctrl.sv
module sis_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sis_pkg::sis_sts_t sts_i,
  output sis_pkg::sis_ctl_t ctl_o
);
  import sis_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PROBE,
    ST_CMP,
    ST_ACT,
    ST_SHIFT_UP,
    ST_WR_NEW,
    ST_SHIFT_DN,
    ST_GET_WAIT,
    ST_FIN
  } state_e;

  state_e   state_q, state_d;
  sis_ctl_t ctl;

  always_comb begin
    state_d = state_q;
    ctl     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          state_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.cmd == CMD_GET) begin
          if (sts_i.idx_ok) begin
            ctl.get_rd = 1'b1;
            state_d    = ST_GET_WAIT;
          end else begin
            state_d = ST_FIN;
          end
        end else if (sts_i.oor) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_PROBE;
        end
      end
      ST_GET_WAIT: begin
        ctl.get_cap = 1'b1;
        state_d     = ST_FIN;
      end
      ST_PROBE: begin
        if (sts_i.search_go) begin
          ctl.probe = 1'b1;
          state_d   = ST_CMP;
        end else begin
          state_d = ST_ACT;
        end
      end
      ST_CMP: begin
        ctl.cmp = 1'b1;
        state_d = ST_PROBE;
      end
      ST_ACT: begin
        unique case (sts_i.cmd)
          CMD_FIND: begin
            ctl.set_ok = sts_i.hit;
            state_d    = ST_FIN;
          end
          CMD_ADD: begin
            if (sts_i.hit) begin
              state_d = ST_FIN;
            end else if (sts_i.full) begin
              ctl.set_full = 1'b1;
              state_d      = ST_FIN;
            end else begin
              ctl.su_init = 1'b1;
              state_d     = ST_SHIFT_UP;
            end
          end
          CMD_REMOVE: begin
            if (sts_i.hit) begin
              ctl.set_ok  = 1'b1;
              ctl.dn_init = 1'b1;
              state_d     = ST_SHIFT_DN;
            end else begin
              state_d = ST_FIN;
            end
          end
          default: begin
            state_d = ST_FIN;
          end
        endcase
      end
      ST_SHIFT_UP: begin
        ctl.su_step = 1'b1;
        if (sts_i.su_last) begin
          state_d = ST_WR_NEW;
        end
      end
      ST_WR_NEW: begin
        ctl.wr_new = 1'b1;
        state_d    = ST_FIN;
      end
      ST_SHIFT_DN: begin
        ctl.dn_step = 1'b1;
        if (sts_i.dn_last) begin
          ctl.cnt_dec = 1'b1;
          state_d     = ST_FIN;
        end
      end
      ST_FIN: begin
        ctl.finish = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy  = (state_q != ST_IDLE);
  assign ctl_o = ctl;

endmodule

>>> hdl/sis_dpath.sv
module sis_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sis_pkg::sis_req_t req_i,
  input  logic              cfg_we_i,
  input  logic [8:0]        cfg_data_i,
  input  sis_pkg::sis_ctl_t ctl_i,
  output sis_pkg::sis_sts_t sts_o,
  output sis_pkg::sis_rsp_t rsp_o,
  output logic              rsp_valid_o
);
  import sis_pkg::*;

  sis_req_t           req_q;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      upg_q;
  logic [CW-1:0]      lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]      mid_q, mid_d;
  logic               hit_q, hit_d;
  logic [CW-1:0]      ptr_q, ptr_d;
  logic               pend_q, pend_d;
  logic [AW-1:0]      pend_a_q, pend_a_d;
  logic               ok_q, ok_d, full_q, full_d, oor_q, oor_d;
  logic signed [15:0] val_q, val_d;
  sis_rsp_t           rsp_q, rsp_d;
  logic               rsp_v_q;

  logic [CW-1:0]      mid_w;
  logic [CW-1:0]      ptr_m1;
  logic               in_fits;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [15:0]        ram_wdata, ram_rdata;
  logic signed [15:0] rd_s, op_s;

  assign mid_w   = lo_q + ((hi_q - lo_q) >> 1);
  assign ptr_m1  = ptr_q - 9'd1;
  assign in_fits = (req_i.operand_value[63:15] == '0) || (req_i.operand_value[63:15] == '1);
  assign rd_s    = $signed(ram_rdata);
  assign op_s    = $signed(req_q.operand_value[15:0]);

  sis_ram #(
    .WIDTH (16),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Read address: search probe, get, or source of a shift move.
  always_comb begin
    priority if (ctl_i.probe) begin
      ram_raddr = mid_w[AW-1:0];
    end else if (ctl_i.get_rd) begin
      ram_raddr = req_q.entry_index;
    end else if (ctl_i.su_step) begin
      ram_raddr = ptr_m1[AW-1:0];
    end else begin
      ram_raddr = ptr_q[AW-1:0];
    end
  end

  // Write port: new entry, or land the move read in the previous cycle.
  always_comb begin
    if (ctl_i.wr_new) begin
      ram_we    = 1'b1;
      ram_waddr = lo_q[AW-1:0];
      ram_wdata = req_q.operand_value[15:0];
    end else begin
      ram_we    = pend_q && (ctl_i.su_step || ctl_i.dn_step);
      ram_waddr = pend_a_q;
      ram_wdata = ram_rdata;
    end
  end

  always_comb begin
    cnt_d    = cnt_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    hit_d    = hit_q;
    ptr_d    = ptr_q;
    pend_d   = pend_q;
    pend_a_d = pend_a_q;
    ok_d     = ok_q;
    full_d   = full_q;
    oor_d    = oor_q;
    val_d    = val_q;

    if (ctl_i.load) begin
      oor_d  = (req_i.command != CMD_GET) && !in_fits;
      lo_d   = (!in_fits && !req_i.operand_value[63]) ? cnt_q : '0;
      hi_d   = cnt_q;
      hit_d  = 1'b0;
      ok_d   = 1'b0;
      full_d = 1'b0;
      val_d  = '0;
    end
    if (ctl_i.probe) begin
      mid_d = mid_w[AW-1:0];
    end
    if (ctl_i.cmp) begin
      if (rd_s < op_s) begin
        lo_d = {1'b0, mid_q} + 9'd1;
      end else if (rd_s > op_s) begin
        hi_d = {1'b0, mid_q};
      end else begin
        lo_d  = {1'b0, mid_q};
        hit_d = 1'b1;
      end
    end
    if (ctl_i.get_cap) begin
      val_d = rd_s;
      ok_d  = 1'b1;
    end
    if (ctl_i.su_init) begin
      ptr_d  = cnt_q;
      pend_d = 1'b0;
    end
    if (ctl_i.su_step) begin
      if (ptr_q > lo_q) begin
        pend_d   = 1'b1;
        pend_a_d = ptr_q[AW-1:0];
        ptr_d    = ptr_q - 9'd1;
      end else begin
        pend_d = 1'b0;
      end
    end
    if (ctl_i.dn_init) begin
      ptr_d  = lo_q + 9'd1;
      pend_d = 1'b0;
    end
    if (ctl_i.dn_step) begin
      if (ptr_q < cnt_q) begin
        pend_d   = 1'b1;
        pend_a_d = ptr_m1[AW-1:0];
        ptr_d    = ptr_q + 9'd1;
      end else begin
        pend_d = 1'b0;
      end
    end
    if (ctl_i.wr_new) begin
      cnt_d = cnt_q + 9'd1;
      ok_d  = 1'b1;
    end
    if (ctl_i.cnt_dec) begin
      cnt_d = cnt_q - 9'd1;
    end
    if (ctl_i.set_full) begin
      full_d = 1'b1;
    end
    if (ctl_i.set_ok) begin
      ok_d = 1'b1;
    end
  end

  always_comb begin
    rsp_d.ok              = ok_q;
    rsp_d.position        = (req_q.command == CMD_GET) ? '0 : lo_q;
    rsp_d.entry_value     = val_q;
    rsp_d.count_now       = cnt_q;
    rsp_d.store_full      = full_q;
    rsp_d.upgrade_advised = oor_q || (cnt_q >= upg_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      upg_q   <= 9'd256;
      rsp_v_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      rsp_v_q <= ctl_i.finish;
      pend_q  <= pend_d;
      if (cfg_we_i) begin
        upg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      req_q <= req_i;
    end
    if (ctl_i.finish) begin
      rsp_q <= rsp_d;
    end
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    hit_q    <= hit_d;
    ptr_q    <= ptr_d;
    pend_a_q <= pend_a_d;
    ok_q     <= ok_d;
    full_q   <= full_d;
    oor_q    <= oor_d;
    val_q    <= val_d;
  end

  assign sts_o.cmd       = req_q.command;
  assign sts_o.idx_ok    = ({1'b0, req_q.entry_index} < cnt_q);
  assign sts_o.oor       = oor_q;
  assign sts_o.search_go = !hit_q && (lo_q < hi_q);
  assign sts_o.hit       = hit_q;
  assign sts_o.full      = (cnt_q >= 9'(CAPACITY));
  assign sts_o.su_last   = (ptr_q == lo_q);
  assign sts_o.dn_last   = (ptr_q >= cnt_q);

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_v_q;

endmodule

>>> test/sorted_int16_set_top_tb.sv
`timescale 1ns / 1ps

module sorted_int16_set_top_tb;
  import sis_pkg::*;

  // Stop the run after this many cycles without any accepted or completed transaction.
  // The limit must cover the slowest command (add at position 0 into 255
  // entries) plus the longest sender gap.
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  // Keep watching for stray results this long once nothing is expected.
  localparam int unsigned TAIL_CYCLES    = 300;

  // Kinds of entries in the sender's work list.
  typedef enum logic [1:0] {
    OP_COMMAND,
    OP_REG_WRITE,
    OP_SETTLE
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    sis_req_t   req;
    logic [8:0] thr;
    logic [3:0] gap;
  } pending_op_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  logic       busy;
  sis_req_t   req       = '0;
  logic       done;
  sis_rsp_t   rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [8:0] cfg_data  = '0;

  // Work list for the sender, filled up front by the stimulus block.
  pending_op_t pending_ops_q[$];
  // Results predicted for accepted commands, oldest first.
  sis_rsp_t    expected_rsp_q[$];

  // Shadow copy of the set and of the upgrade threshold.
  logic signed [15:0] shadow_vals [CAPACITY];
  int                 shadow_count = 0;
  logic [8:0]         shadow_thr   = 9'd256;

  // Sender state.
  pending_op_t cur_op;
  bit          op_loaded   = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned in_flight   = 0;
  bit          raise_start;
  bit          raise_cfg;

  // Generator state.
  logic signed [15:0] added_vals[$];
  bit                 no_gaps     = 1'b0;
  bit                 narrow_pool = 1'b1;
  int unsigned        reuse_pct   = 45;

  // Checker state.
  int unsigned mismatches   = 0;
  int unsigned rsp_seen     = 0;
  int unsigned stall_cycles = 0;
  sis_rsp_t    want_rsp;

  sorted_int16_set_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .done_o      (done),
    .rsp_o       (rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one command to the shadow set and return the result it must give.
  function automatic sis_rsp_t apply_set_command(sis_req_t rq);
    sis_rsp_t           r;
    logic signed [63:0] opv;
    logic signed [15:0] v;
    int                 lo;
    int                 hi;
    int                 mid;
    int                 pos;
    bit                 hit;
    r   = '0;
    opv = rq.operand_value;
    if (rq.command == CMD_GET) begin
      if (int'(rq.entry_index) < shadow_count) begin
        r.ok          = 1'b1;
        r.entry_value = shadow_vals[rq.entry_index];
      end
    end else if (opv < -64'sd32768 || opv > 64'sd32767) begin
      // Operand wider than int16: miss at either end, set untouched.
      r.upgrade_advised = 1'b1;
      r.position        = opv[63] ? 9'd0 : shadow_count[8:0];
    end else begin
      v   = opv[15:0];
      lo  = 0;
      hi  = shadow_count;
      mid = 0;
      hit = 1'b0;
      while (lo < hi && !hit) begin
        mid = lo + (hi - lo) / 2;
        if (shadow_vals[mid] < v) lo = mid + 1;
        else if (shadow_vals[mid] > v) hi = mid;
        else hit = 1'b1;
      end
      pos        = hit ? mid : lo;
      r.position = pos[8:0];
      case (rq.command)
        CMD_FIND: r.ok = hit;
        CMD_ADD: begin
          // Duplicates are refused; a full set flags the refusal.
          if (!hit) begin
            if (shadow_count >= CAPACITY) begin
              r.store_full = 1'b1;
            end else begin
              for (int k = shadow_count; k > pos; k--) shadow_vals[k] = shadow_vals[k-1];
              shadow_vals[pos] = v;
              shadow_count++;
              r.ok = 1'b1;
            end
          end
        end
        default: begin
          if (hit) begin
            for (int k = pos; k + 1 < shadow_count; k++) shadow_vals[k] = shadow_vals[k+1];
            shadow_count--;
            r.ok = 1'b1;
          end
        end
      endcase
    end
    if (shadow_count >= int'(shadow_thr)) r.upgrade_advised = 1'b1;
    r.count_now = shadow_count[8:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  // Queue one command; draw the gap before it, with runs of back-to-back
  // commands mixed in.
  task automatic push_command(input sis_cmd_e c, input longint v, input logic [7:0] idx);
    pending_op_t op;
    op                   = '0;
    op.kind              = OP_COMMAND;
    op.req.command       = c;
    op.req.operand_value = v;
    op.req.entry_index   = idx;
    if ($urandom_range(0, 49) == 0) no_gaps = !no_gaps;
    op.gap = no_gaps ? 4'd0 : 4'($urandom_range(0, 14));
    pending_ops_q.push_back(op);
    // Remember added values so later commands can hit them.
    if (c == CMD_ADD && v >= -32768 && v <= 32767) added_vals.push_back(v[15:0]);
  endtask

  task automatic push_reg_write(input logic [8:0] thr);
    pending_op_t op;
    op      = '0;
    op.kind = OP_REG_WRITE;
    op.thr  = thr;
    pending_ops_q.push_back(op);
  endtask

  task automatic push_settle();
    pending_op_t op;
    op      = '0;
    op.kind = OP_SETTLE;
    pending_ops_q.push_back(op);
  endtask

  function automatic longint pick_operand();
    logic signed [15:0] s;
    int unsigned        r;
    r = $urandom_range(0, 99);
    s = 16'($urandom);
    if (r < 8) return {$urandom, $urandom};
    if (r < 11) begin
      case ($urandom_range(0, 3))
        0:       return -64'sd32769;
        1:       return 64'sd32768;
        2:       return -64'sd32768;
        default: return 64'sd32767;
      endcase
    end
    if (r < 11 + reuse_pct && added_vals.size() > 0)
      return longint'(added_vals[$urandom_range(0, added_vals.size() - 1)]);
    if (narrow_pool) return longint'(int'($urandom_range(0, 40)) - 20);
    return longint'(s);
  endfunction

  task automatic push_random(input int add_pct, input int rem_pct, input int get_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < add_pct)
      push_command(CMD_ADD, pick_operand(), 8'($urandom));
    else if (r < add_pct + rem_pct)
      push_command(CMD_REMOVE, pick_operand(), 8'($urandom));
    else if (r < add_pct + rem_pct + get_pct)
      push_command(CMD_GET, pick_operand(),
                   $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 31)));
    else
      push_command(CMD_FIND, pick_operand(), 8'($urandom));
    // Now and then, hold the sender until every result is back.
    if ($urandom_range(0, 99) == 0) push_settle();
  endtask

  // Sender: take the next transaction from the work list, hold start until
  // the block accepts it, and predict its result at the accepting edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
      op_loaded = 1'b0;
      in_flight = 0;
    end else begin
      if (done && in_flight > 0) in_flight--;
      if (start && !busy) begin
        expected_rsp_q.push_back(apply_set_command(req));
        in_flight++;
        op_loaded = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        shadow_thr = cfg_data;
        op_loaded  = 1'b0;
      end
      if (!op_loaded && pending_ops_q.size() > 0) begin
        cur_op      = pending_ops_q.pop_front();
        op_loaded   = 1'b1;
        hold_cycles = 32'(cur_op.gap);
      end
      raise_start = 1'b0;
      raise_cfg   = 1'b0;
      if (op_loaded) begin
        if (hold_cycles > 0) begin
          hold_cycles--;
        end else begin
          case (cur_op.kind)
            OP_COMMAND:   raise_start = 1'b1;
            // Write the register only once the block has gone idle.
            OP_REG_WRITE: raise_cfg = (in_flight == 0) && !busy;
            default: begin
              if (in_flight == 0) op_loaded = 1'b0;
            end
          endcase
        end
      end
      // Keep start high across back-to-back commands; assign it once per edge.
      start     <= raise_start;
      cfg_valid <= raise_cfg;
      if (raise_start) req <= cur_op.req;
      if (raise_cfg) cfg_data <= cur_op.thr;
    end
  end

  // Monitor: compare each result with the oldest prediction, field by field.
  always @(posedge clk) begin
    if (rst_n && done) begin
      rsp_seen++;
      if (expected_rsp_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing predicted", rsp_seen));
      end else begin
        want_rsp = expected_rsp_q.pop_front();
        if (rsp.ok !== want_rsp.ok)
          report_mismatch($sformatf("result %0d ok %b, predicted %b",
                                    rsp_seen, rsp.ok, want_rsp.ok));
        if (rsp.position !== want_rsp.position)
          report_mismatch($sformatf("result %0d position %0d, predicted %0d",
                                    rsp_seen, rsp.position, want_rsp.position));
        if (rsp.entry_value !== want_rsp.entry_value)
          report_mismatch($sformatf("result %0d entry_value %0d, predicted %0d",
                                    rsp_seen, rsp.entry_value, want_rsp.entry_value));
        if (rsp.count_now !== want_rsp.count_now)
          report_mismatch($sformatf("result %0d count_now %0d, predicted %0d",
                                    rsp_seen, rsp.count_now, want_rsp.count_now));
        if (rsp.store_full !== want_rsp.store_full)
          report_mismatch($sformatf("result %0d store_full %b, predicted %b",
                                    rsp_seen, rsp.store_full, want_rsp.store_full));
        if (rsp.upgrade_advised !== want_rsp.upgrade_advised)
          report_mismatch($sformatf("result %0d upgrade_advised %b, predicted %b",
                                    rsp_seen, rsp.upgrade_advised, want_rsp.upgrade_advised));
      end
    end
  end

  // Watchdog: count cycles in which no transaction of any kind is accepted or completed.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("[sorted_int16_set_top] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    // Directed part, with the threshold at zero so the hint is always set.
    push_reg_write(9'd0);
    push_command(CMD_GET,    0, 8'd0);      // get from an empty set
    push_command(CMD_FIND,   0, 8'd0);
    push_command(CMD_REMOVE, 5, 8'd0);      // remove a value not held
    push_command(CMD_ADD,    32767, 8'd0);
    push_command(CMD_ADD,    -32768, 8'd0);
    push_command(CMD_ADD,    0, 8'd0);
    push_command(CMD_ADD,    0, 8'd0);      // duplicate add
    push_command(CMD_FIND,   -32768, 8'd0);
    push_command(CMD_FIND,   32767, 8'd0);
    push_command(CMD_FIND,   1, 8'd0);      // miss with an insert position
    push_command(CMD_FIND,   32768, 8'd0);  // just above int16
    push_command(CMD_FIND,   -32769, 8'd0); // just below int16
    push_command(CMD_ADD,    64'sh7FFF_FFFF_FFFF_FFFF, 8'hFF);
    push_command(CMD_ADD,    64'sh8000_0000_0000_0000, 8'hFF);
    push_command(CMD_REMOVE, 64'shFFFF_FFFF_0000_0000, 8'h55);
    push_command(CMD_GET,    0, 8'd0);
    push_command(CMD_GET,    0, 8'd1);
    push_command(CMD_GET,    0, 8'd2);
    push_command(CMD_GET,    0, 8'd255);    // index past the count
    push_command(CMD_REMOVE, 0, 8'd0);
    push_command(CMD_REMOVE, 0, 8'd0);      // remove again: miss
    push_command(CMD_GET,    0, 8'd2);

    // Small values with frequent hits; threshold inside the working range.
    push_reg_write(9'($urandom_range(2, 30)));
    for (int i = 0; i < 400; i++) push_random(35, 25, 15);

    // Fill the set with wide values until adds are refused as full.
    narrow_pool = 1'b0;
    reuse_pct   = 10;
    push_reg_write(9'd256);
    for (int i = 0; i < 450; i++) push_random(80, 3, 8);

    // Churn near full.
    reuse_pct = 50;
    push_reg_write(9'd255);
    for (int i = 0; i < 400; i++) push_random(30, 25, 20);

    // Drain the set, moving the threshold on the way down.
    reuse_pct = 70;
    push_reg_write(9'd128);
    for (int i = 0; i < 200; i++) push_random(10, 60, 15);
    push_reg_write(9'd1);
    for (int i = 0; i < 200; i++) push_random(10, 60, 15);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops_q.size() != 0 || op_loaded || in_flight != 0 ||
           expected_rsp_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_rsp_q.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived",
                                expected_rsp_q.size()));

    if (mismatches == 0) begin
      $display("[sorted_int16_set_top] OK");
    end else begin
      $display("[sorted_int16_set_top] ERROR");
    end
    $finish;
  end

endmodule

>>> sorted_int16_set_top.f
hdl/sis_pkg.sv
hdl/sis_ram.sv
hdl/sis_ctrl.sv
hdl/sis_dpath.sv
hdl/sorted_int16_set_top.sv
test/sorted_int16_set_top_tb.sv
